>>> rtl/core/ohc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohc_pkg
// Shared codes, widths and controller/datapath interface types for the
// opposing homozygote counter.
// ----------------------------------------------------------------------------
package ohc_pkg;

  localparam int MAX_ROWS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int OP_W    = 2;
  localparam int GT_W    = 2;
  localparam int IDX_W   = 10;
  localparam int TOTAL_W = 16;
  localparam int ROWS_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [GT_W-1:0] GT_ZERO = 2'd0;
  localparam logic [GT_W-1:0] GT_TWO  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIQUE_MODE = 2'd1;

  localparam int ROW_COUNT_RST = 1024;

  typedef struct packed {
    logic push;        // store element, update column counts
    logic read;        // issue counter read at requested row
    logic clr_start;   // zero column position, counts and sweep pointer
    logic clr_write;   // write zero at sweep pointer, advance
    logic pass_issue;  // read column and counter at sweep pointer, advance
  } ohc_cmd_t;

  typedef struct packed {
    logic col_pass;    // this push closes a column that needs a pass
    logic pass_last;   // sweep pointer at last row of the pass
    logic clr_last;    // sweep pointer at last entry of the memory
  } ohc_stat_t;

endpackage

>>> rtl/core/ohc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohc_ctrl
// Sequencer: decodes commands, runs the clearing sweep and column pass,
// and times the read result strobe.
// ----------------------------------------------------------------------------
module ohc_ctrl import ohc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] in_op,
  input  ohc_stat_t       stat,
  output ohc_cmd_t        cmd,
  output logic            busy,
  output logic            out_valid
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_PASS = 3'd2;
  localparam logic [2:0] ST_TAIL = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_op)
            OP_PUSH: begin
              cmd.push = 1'b1;
              if (stat.col_pass) state_nxt = ST_PASS;
            end
            OP_READ: begin
              cmd.read  = 1'b1;
              state_nxt = ST_RD;
            end
            OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_PASS: begin
        cmd.pass_issue = 1'b1;
        if (stat.pass_last) state_nxt = ST_TAIL;
      end
      ST_TAIL: state_nxt = ST_IDLE;   // last row's write lands here
      ST_RD: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_strobe_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.read)) else $error("result strobe without read beat");

  a_pass_enters_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pass_issue && stat.pass_last) |=> (state_r == ST_TAIL))
    else $error("column pass did not drain");

endmodule

>>> rtl/core/ohc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohc_datapath
// Column store, row counter memory, column position and counts, the
// configuration registers and the pass pipeline.
// ----------------------------------------------------------------------------
module ohc_datapath import ohc_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ohc_cmd_t              cmd,
  output ohc_stat_t             stat,
  input  logic [GT_W-1:0]       in_genotype,
  input  logic [IDX_W-1:0]      in_row_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [TOTAL_W-1:0]    out_row_total
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (AW + 1 > ROWS_W) ? AW + 1 : ROWS_W;
  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  logic [GT_W-1:0]        col_mem [MAX_ROWS];
  logic [COUNT_WIDTH-1:0] cnt_mem [MAX_ROWS];

  logic [ROWS_W-1:0] row_count_r;
  logic              unique_mode_r;
  logic [AW-1:0]     pos_r;
  logic [1:0]        zeros_r, twos_r;
  logic [1:0]        zeros_nxt, twos_nxt;
  logic [AW-1:0]     p_r;
  logic [AW-1:0]     pass_last_r;
  logic              mark_zeros_r, mark_twos_r;
  logic              s1_v_r;
  logic [AW-1:0]     s1_addr_r;
  logic [GT_W-1:0]   col_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic              rd_zero_r;

  logic [CW-1:0]     rc_ext, rows_eff, pos_inc;
  logic              col_end;
  logic [IW:0]       idx_ext;
  logic              idx_ok;
  logic [AW-1:0]     idx_addr, rd_addr, wr_addr;
  logic              rd_en, wr_en, inc;
  logic [COUNT_WIDTH-1:0] bumped, wr_data;
  logic [31:0]       total_wide;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= ROWS_W'(ROW_COUNT_RST);
      unique_mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROW_COUNT)   row_count_r   <= cfg_data[ROWS_W-1:0];
      if (cfg_index == REG_UNIQUE_MODE) unique_mode_r <= cfg_data[0];
    end
  end

  // Clamp the row count into 1..MAX_ROWS
  always_comb begin
    rc_ext = CW'(row_count_r);
    priority if (rc_ext == '0)              rows_eff = CW'(1);
    else if (rc_ext > CW'(MAX_ROWS))        rows_eff = CW'(MAX_ROWS);
    else                                    rows_eff = rc_ext;
  end

  assign pos_inc   = CW'(pos_r) + CW'(1);
  assign col_end   = (pos_inc >= rows_eff);
  assign zeros_nxt = (in_genotype == GT_ZERO && zeros_r != 2'd2) ? zeros_r + 2'd1 : zeros_r;
  assign twos_nxt  = (in_genotype == GT_TWO  && twos_r  != 2'd2) ? twos_r  + 2'd1 : twos_r;

  assign stat.col_pass  = col_end && (zeros_nxt != 2'd0) && (twos_nxt != 2'd0);
  assign stat.pass_last = (p_r == pass_last_r);
  assign stat.clr_last  = (p_r == AW'(MAX_ROWS - 1));

  // Column position, counts and pass setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      zeros_r <= '0;
      twos_r  <= '0;
    end else if (cmd.clr_start) begin
      pos_r   <= '0;
      zeros_r <= '0;
      twos_r  <= '0;
    end else if (cmd.push) begin
      if (col_end) begin
        pos_r   <= '0;
        zeros_r <= '0;
        twos_r  <= '0;
      end else begin
        pos_r   <= pos_inc[AW-1:0];
        zeros_r <= zeros_nxt;
        twos_r  <= twos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && col_end) begin
      mark_zeros_r <= (zeros_nxt == 2'd1) || unique_mode_r;
      mark_twos_r  <= (twos_nxt == 2'd1) || unique_mode_r;
      pass_last_r  <= AW'(rows_eff - CW'(1));
    end
  end

  // Sweep pointer shared by the clearing sweep and the column pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
    end else if (cmd.clr_start || (cmd.push && col_end)) begin
      p_r <= '0;
    end else if (cmd.clr_write || cmd.pass_issue) begin
      p_r <= p_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.pass_issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= p_r;
  end

  // Column store
  always_ff @(posedge clk) begin
    if (cmd.push) col_mem[pos_r] <= in_genotype;
    if (cmd.pass_issue) col_q <= col_mem[p_r];
  end

  // Counter memory ports
  assign idx_ext  = (IW+1)'(in_row_index);
  assign idx_ok   = (idx_ext < (IW+1)'(MAX_ROWS));
  assign idx_addr = idx_ext[AW-1:0];
  assign rd_en    = cmd.read || cmd.pass_issue;
  assign rd_addr  = cmd.read ? idx_addr : p_r;

  assign inc     = (mark_twos_r && col_q == GT_TWO) || (mark_zeros_r && col_q == GT_ZERO);
  assign bumped  = (inc && cnt_q != '1) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;
  assign wr_en   = cmd.clr_write || s1_v_r;
  assign wr_addr = cmd.clr_write ? p_r : s1_addr_r;
  assign wr_data = cmd.clr_write ? '0 : bumped;

  always_ff @(posedge clk) begin
    if (wr_en) cnt_mem[wr_addr] <= wr_data;
    if (rd_en) cnt_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.read) rd_zero_r <= !idx_ok;
  end

  assign total_wide    = rd_zero_r ? 32'd0 : 32'(cnt_q);
  assign out_row_total = total_wide[TOTAL_W-1:0];

  a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pass_issue |-> (p_r <= pass_last_r)) else $error("pass beyond row count");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !cmd.clr_write) else $error("pass write collides with clear sweep");

endmodule

>>> rtl/core/opposing_homozygote_counter.sv
`timescale 1ns / 1ps
// Push: a push that closes a column whose elements hold both a 0 and a 2
//   keeps busy high for the pass (one row per cycle over the effective row count) and its drain.
// Read: result strobe in the cycle after the beat, with busy high. Receiver cannot stall.
// Clear: busy while the sweep zeroes every counter entry, one entry per cycle.
// Reset: after rst_n rises, a clearing sweep over every counter entry runs with busy high;
//   configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// opposing_homozygote_counter
// Counts, per row, the columns in which that row is an opposing homozygote.
// ----------------------------------------------------------------------------
module opposing_homozygote_counter import ohc_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_op,
  input  logic [GT_W-1:0]       in_genotype,
  input  logic [IDX_W-1:0]      in_row_index,
  output logic                  out_valid,
  output logic [TOTAL_W-1:0]    out_row_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ohc_cmd_t  cmd;
  ohc_stat_t stat;

  assign cfg_ready = 1'b1;

  ohc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ohc_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_genotype   (in_genotype),
    .in_row_index  (in_row_index),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_row_total (out_row_total)
  );

endmodule

>>> tb/ohc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohc_checker
// Watches the command, result and register channels of the opposing
// homozygote counter. It keeps its own copy of the column store, the row
// tallies and the settings, queues the row total that each read beat must
// return, and compares every result strobe against the oldest queued total.
// ----------------------------------------------------------------------------
module ohc_checker import ohc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [OP_W-1:0]       in_op,
  input  logic [GT_W-1:0]       in_genotype,
  input  logic [IDX_W-1:0]      in_row_index,
  input  logic                  out_valid,
  input  logic [TOTAL_W-1:0]    out_row_total,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    due_count
);

  logic [TOTAL_W-1:0] tallies [MAX_ROWS_DEF];
  logic [GT_W-1:0]    column_codes [MAX_ROWS_DEF];
  logic [TOTAL_W-1:0] totals_due [$];
  logic [TOTAL_W-1:0] want;
  logic [ROWS_W-1:0]  rows_reg;
  logic               unique_reg;
  int unsigned        col_pos;
  int unsigned        span;
  int                 zeros_seen;
  int                 twos_seen;
  int                 errors = 0;
  bit                 hit_twos;
  bit                 hit_zeros;

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tallies[r]) tallies[r] = '0;
      col_pos    = 0;
      zeros_seen = 0;
      twos_seen  = 0;
      rows_reg   = ROWS_W'(ROW_COUNT_RST);
      unique_reg = 1'b0;
      totals_due.delete();
    end else begin
      if (out_valid) begin
        if (totals_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected row_total beat, expected none, actual %0d",
                   $time, out_row_total);
        end else begin
          want = totals_due.pop_front();
          if (out_row_total !== want) begin
            errors++;
            $display("%0t: row_total mismatch, expected %0d, actual %0d",
                     $time, want, out_row_total);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT:   rows_reg = cfg_data;
          REG_UNIQUE_MODE: unique_reg = cfg_data[0];
          default: ;
        endcase
      end

      if (start && !busy) begin
        case (in_op)
          OP_PUSH: begin
            // zero acts as one row, anything past the store acts as a full store
            span = (rows_reg == 0) ? 1 :
                   (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_reg;
            if (col_pos < MAX_ROWS_DEF) column_codes[col_pos] = in_genotype;
            if (in_genotype == GT_ZERO && zeros_seen < 2) zeros_seen++;
            if (in_genotype == GT_TWO && twos_seen < 2) twos_seen++;
            col_pos++;
            if (col_pos >= span) begin
              if (zeros_seen != 0 && twos_seen != 0) begin
                hit_twos  = (twos_seen == 1) || unique_reg;
                hit_zeros = (zeros_seen == 1) || unique_reg;
                for (int r = 0; r < span; r++) begin
                  if ((hit_twos && column_codes[r] == GT_TWO) ||
                      (hit_zeros && column_codes[r] == GT_ZERO)) begin
                    if (tallies[r] != {TOTAL_W{1'b1}}) tallies[r] = tallies[r] + 1'b1;
                  end
                end
              end
              col_pos    = 0;
              zeros_seen = 0;
              twos_seen  = 0;
            end
          end
          OP_READ: totals_due.push_back(tallies[in_row_index]);
          OP_CLEAR: begin
            foreach (tallies[r]) tallies[r] = '0;
            col_pos    = 0;
            zeros_seen = 0;
            twos_seen  = 0;
          end
          default: ;
        endcase
      end
    end
    due_count  <= totals_due.size();
    fail_count <= errors;
  end

endmodule

>>> tb/opposing_homozygote_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opposing_homozygote_counter_test
// Drives genotype columns, row reads and clears into the counter under a
// series of row counts and counting modes, with random start gaps, while
// the checker beside the block predicts every row total.
// ----------------------------------------------------------------------------
module opposing_homozygote_counter_test;
  import ohc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [GT_W-1:0] GT_HET    = 2'd1;
  localparam logic [GT_W-1:0] GT_ODD    = 2'd3;
  localparam int SETTLE_CYCLES = MAX_ROWS_DEF + 8;
  localparam int TOTAL_ITEMS   = 1100;
  localparam int QUIET_ITEMS   = 150;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       in_op = OP_PUSH;
  logic [GT_W-1:0]       in_genotype = GT_ZERO;
  logic [IDX_W-1:0]      in_row_index = '0;
  logic                  out_valid;
  logic [TOTAL_W-1:0]    out_row_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ROW_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int due;
  int sent = 0;
  bit gaps_on = 1'b1;

  opposing_homozygote_counter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_genotype   (in_genotype),
    .in_row_index  (in_row_index),
    .out_valid     (out_valid),
    .out_row_total (out_row_total),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ohc_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_genotype   (in_genotype),
    .in_row_index  (in_row_index),
    .out_valid     (out_valid),
    .out_row_total (out_row_total),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (mismatches),
    .due_count     (due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [GT_W-1:0] pick_code(input int hom_pct);
    if ($urandom_range(0, 99) < hom_pct)
      return ($urandom_range(0, 1) != 0) ? GT_TWO : GT_ZERO;
    return ($urandom_range(0, 1) != 0) ? GT_ODD : GT_HET;
  endfunction

  // Hold the beat until the block takes it; start stays up for the next one.
  // Drop the gaps in the quiet tail at the end of the run.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [GT_W-1:0] gt,
                           input logic [IDX_W-1:0] idx);
    if (gaps_on && (sent < TOTAL_ITEMS - QUIET_ITEMS) && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_genotype  <= gt;
    in_row_index <= idx;
    do @(posedge clk); while (busy);
    if (op != OP_UNUSED) sent++;
  endtask

  // Drain: wait for every read to return, then let a pass or clear finish.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [ROWS_W-1:0] rows, input logic uniq);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_UNIQUE_MODE;
    cfg_data  <= CFG_DATA_W'(uniq);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int span;
    int depth;
    int cols;
    logic [ROWS_W-1:0] rows;
    bit broken;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // freshly cleared tallies, and an unused op that must do nothing
    send_item(OP_READ, GT_ZERO, '0);
    send_item(OP_READ, GT_ODD, '1);
    send_item(OP_UNUSED, GT_ODD, '1);

    // open a full-size column, then shrink the row count under it
    send_item(OP_PUSH, GT_ZERO, '0);
    send_item(OP_PUSH, GT_TWO, '0);
    settle();
    set_mode(11'd2, 1'b0);
    send_item(OP_PUSH, GT_HET, '0);
    send_item(OP_READ, GT_ZERO, 10'd0);
    send_item(OP_READ, GT_ZERO, 10'd1);

    // zero rows behaves as single-row columns: never both codes
    settle();
    set_mode(11'd0, 1'b0);
    send_item(OP_PUSH, GT_ZERO, '0);
    send_item(OP_PUSH, GT_TWO, '0);
    send_item(OP_READ, GT_ZERO, 10'd0);

    settle();
    set_mode(11'd3, 1'b1);
    send_item(OP_PUSH, GT_ZERO, '0);
    send_item(OP_PUSH, GT_ZERO, '0);
    send_item(OP_PUSH, GT_TWO, '0);
    send_item(OP_READ, GT_ZERO, 10'd0);
    send_item(OP_READ, GT_ZERO, 10'd2);

    // without unique mode the doubled zero does not count
    settle();
    set_mode(11'd3, 1'b0);
    send_item(OP_PUSH, GT_ZERO, '0);
    send_item(OP_PUSH, GT_ZERO, '0);
    send_item(OP_PUSH, GT_TWO, '0);
    send_item(OP_READ, GT_ZERO, 10'd1);
    send_item(OP_READ, GT_ZERO, 10'd2);
    send_item(OP_CLEAR, GT_ZERO, '0);
    send_item(OP_READ, GT_ZERO, 10'd2);

    // one column over the whole store, row count above the maximum
    settle();
    set_mode('1, 1'($urandom_range(0, 1)));
    for (int r = 0; r < MAX_ROWS_DEF; r++) send_item(OP_PUSH, pick_code(2), IDX_W'($urandom));
    send_item(OP_READ, GT_ZERO, 10'd1023);
    repeat (8) send_item(OP_READ, pick_code(50), IDX_W'($urandom));

    while (sent < TOTAL_ITEMS) begin
      settle();
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0: rows = '0;
        1, 2, 3: rows = ROWS_W'($urandom_range(7, 40));
        default: rows = ROWS_W'($urandom_range(1, 6));
      endcase
      set_mode(rows, 1'($urandom_range(0, 1)));
      span = (rows == 0) ? 1 : int'(rows);
      cols = $urandom_range(2, 8);
      for (int c = 0; c < cols; c++) begin
        broken = ($urandom_range(0, 24) == 0);
        depth  = broken ? $urandom_range(0, span - 1) : span;
        for (int e = 0; e < depth; e++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(OP_UNUSED, pick_code(50), IDX_W'($urandom));
          if ($urandom_range(0, 9) == 0)
            send_item(OP_READ, pick_code(50), ($urandom_range(0, 4) == 0) ?
                      IDX_W'($urandom) : IDX_W'($urandom_range(0, span + 1)));
          send_item(OP_PUSH, pick_code(75), IDX_W'($urandom));
        end
        if (broken) send_item(OP_CLEAR, pick_code(50), IDX_W'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          for (int r = 0; r < span && r < 8; r++)
            send_item(OP_READ, pick_code(50), IDX_W'(r));
        end
      end
      // push a partial or full column; a partial one leaves the next setting in mid column
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, span)) send_item(OP_PUSH, pick_code(75), IDX_W'($urandom));
      end
    end

    settle();
    if (mismatches == 0 && due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ohc_pkg.sv
rtl/core/ohc_ctrl.sv
rtl/core/ohc_datapath.sv
rtl/core/opposing_homozygote_counter.sv
tb/ohc_checker.sv
tb/opposing_homozygote_counter_test.sv
